// ----- rtl/pfrc_pkg.sv -----
// Shared types and constants of the packet filter rule chain block.
package pfrc_pkg;

  localparam int unsigned RulesDefault = 16;

  typedef enum logic [2:0] {
    MODE_APPEND  = 3'd0,
    MODE_INSERT  = 3'd1,
    MODE_REPLACE = 3'd2,
    MODE_DELETE  = 3'd3,
    MODE_CLEAR   = 3'd4,
    MODE_TEST    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAIN = 2'd1,
    ST_NO_ENTRY  = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_INPUT   = 2'd0,
    CFG_FORWARD = 2'd1,
    CFG_OUTPUT  = 2'd2
  } cfg_e;

  localparam logic [1:0] TgtDrop   = 2'd1;
  localparam logic [1:0] TgtAccept = 2'd2;

  localparam int unsigned FlagProto = 4;
  localparam int unsigned NegShift  = 7;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DEC    = 8'b0000_0010,
    S_WALK   = 8'b0000_0100,
    S_READ   = 8'b0000_1000,
    S_CMP    = 8'b0001_0000,
    S_APPLY  = 8'b0010_0000,
    S_CLEAR  = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_e;

  // Rule payload kept in the pool.
  typedef struct packed {
    logic [47:0] smac;
    logic [47:0] dmac;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [1:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [13:0] flags;
    logic [1:0]  target;
  } rule_t;

  function automatic logic field_ok(logic [13:0] rf, logic [13:0] tf, int unsigned bit_i,
                                    logic eq);
    logic r;
    r = 1'b1;
    if (rf[bit_i]) begin
      if (!tf[bit_i]) r = 1'b0;
      else r = eq ^ rf[bit_i+NegShift];
    end
    return r;
  endfunction

endpackage

// ----- rtl/packet_filter_rule_chain.sv -----
// Top level of the packet filter rule chain block.
// One transaction is taken at a time and ready stays low until its result is taken. A test
// walks the chain's linked list through the rule memory after the decode state DEC, each entry
// passing through WALK (issue the registered read), READ (wait) and CMP (compare); the number
// of entries walked is at most RULES. Append, insert, replace and delete step through the
// links at one entry per cycle, and a clear returns one entry per cycle to the free list.
// The rule memory needs no clearing pass after reset.
module packet_filter_rule_chain #(
  parameter int unsigned RULES = pfrc_pkg::RulesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [1:0]  chain_i,
  input  logic [7:0]  index_i,
  input  logic [1:0]  target_i,
  input  logic [47:0] src_mac_i,
  input  logic [47:0] dst_mac_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [1:0]  proto_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [13:0] match_flags_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        differs_o,
  output logic [1:0]  verdict_o,
  output logic        rule_hit_o,
  output logic [7:0]  hit_position_o
);

  localparam int unsigned LW = $clog2(RULES + 1);
  localparam int unsigned IW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam logic [LW-1:0] None = LW'(RULES);

  pfrc_pkg::state_e state_q, state_d;

  pfrc_pkg::rule_t mem [RULES];
  pfrc_pkg::rule_t rd_q;
  logic [LW-1:0] link_q [RULES];
  logic [LW-1:0] head_q [3];
  logic [LW-1:0] free_q;
  logic [1:0]    dflt_q [3];

  logic [2:0]    mode_q;
  logic [1:0]    chain_q;
  logic [7:0]    idx_q;
  pfrc_pkg::rule_t pkt_q;
  logic [LW-1:0] cur_q, prev_q;
  logic [8:0]    pos_q;
  logic [1:0]    status_q, verdict_q;
  logic          differs_q, hit_q, busy_q;
  logic [7:0]    hpos_q;

  logic          cur_ok, want_pos, match;
  logic [IW-1:0] cur_ix, prev_ix, free_ix;

  assign in_ready_o     = state_q == pfrc_pkg::S_IDLE;
  assign out_valid_o    = state_q == pfrc_pkg::S_RESULT;
  assign status_o       = status_q;
  assign differs_o      = differs_q;
  assign verdict_o      = verdict_q;
  assign rule_hit_o     = hit_q;
  assign hit_position_o = hpos_q;

  assign cur_ok  = cur_q < None;
  assign cur_ix  = cur_q[IW-1:0];
  assign prev_ix = prev_q[IW-1:0];
  assign free_ix = free_q[IW-1:0];
  assign want_pos = (mode_q == pfrc_pkg::MODE_APPEND) ? 1'b0 : (pos_q == {1'b0, idx_q});

  always_comb begin
    logic pok;
    logic tnp, rnp;
    tnp = pkt_q.flags[pfrc_pkg::FlagProto + pfrc_pkg::NegShift];
    rnp = rd_q.flags[pfrc_pkg::FlagProto + pfrc_pkg::NegShift];
    pok = (pkt_q.proto != 2'd0 && rd_q.proto != 2'd0 &&
           pfrc_pkg::field_ok(rd_q.flags, pkt_q.flags, pfrc_pkg::FlagProto,
                              pkt_q.proto == rd_q.proto))
        || (pkt_q.proto == 2'd0 && !tnp && rd_q.proto == 2'd0 && !rnp)
        || (pkt_q.proto != 2'd0 && rd_q.proto == 2'd0 && !rnp);
    match = (rd_q.target == pfrc_pkg::TgtDrop || rd_q.target == pfrc_pkg::TgtAccept)
        && pfrc_pkg::field_ok(rd_q.flags, pkt_q.flags, 0, rd_q.smac == pkt_q.smac)
        && pfrc_pkg::field_ok(rd_q.flags, pkt_q.flags, 1, rd_q.dmac == pkt_q.dmac)
        && pfrc_pkg::field_ok(rd_q.flags, pkt_q.flags, 2, rd_q.sip == pkt_q.sip)
        && pfrc_pkg::field_ok(rd_q.flags, pkt_q.flags, 3, rd_q.dip == pkt_q.dip)
        && pok
        && pfrc_pkg::field_ok(rd_q.flags, pkt_q.flags, 5, rd_q.sport == pkt_q.sport)
        && pfrc_pkg::field_ok(rd_q.flags, pkt_q.flags, 6, rd_q.dport == pkt_q.dport);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfrc_pkg::S_IDLE: if (in_valid_i) state_d = pfrc_pkg::S_DEC;
      pfrc_pkg::S_DEC: begin
        state_d = pfrc_pkg::S_RESULT;
        case (mode_q)
          pfrc_pkg::MODE_APPEND, pfrc_pkg::MODE_INSERT, pfrc_pkg::MODE_CLEAR,
          pfrc_pkg::MODE_TEST: begin
            if (chain_q == 2'd3) state_d = pfrc_pkg::S_RESULT;
            else if (mode_q == pfrc_pkg::MODE_CLEAR) state_d = pfrc_pkg::S_CLEAR;
            else if (mode_q == pfrc_pkg::MODE_TEST) state_d = pfrc_pkg::S_WALK;
            else if (free_q >= None) state_d = pfrc_pkg::S_RESULT;
            else state_d = pfrc_pkg::S_WALK;
          end
          pfrc_pkg::MODE_REPLACE, pfrc_pkg::MODE_DELETE: begin
            if (chain_q != 2'd3) state_d = pfrc_pkg::S_WALK;
          end
          default: ;
        endcase
      end
      pfrc_pkg::S_WALK: begin
        if (!cur_ok || pos_q >= 9'(RULES)) begin
          if (mode_q == pfrc_pkg::MODE_TEST) state_d = pfrc_pkg::S_RESULT;
          else state_d = pfrc_pkg::S_APPLY;
        end else if (mode_q == pfrc_pkg::MODE_TEST) begin
          state_d = pfrc_pkg::S_READ;
        end else if (want_pos) begin
          state_d = pfrc_pkg::S_APPLY;
        end
      end
      pfrc_pkg::S_READ:   state_d = pfrc_pkg::S_CMP;
      pfrc_pkg::S_CMP:    state_d = match ? pfrc_pkg::S_RESULT : pfrc_pkg::S_WALK;
      pfrc_pkg::S_APPLY:  state_d = pfrc_pkg::S_RESULT;
      pfrc_pkg::S_CLEAR:  if (!cur_ok || pos_q >= 9'(RULES)) state_d = pfrc_pkg::S_RESULT;
      pfrc_pkg::S_RESULT: if (out_ready_i) state_d = pfrc_pkg::S_IDLE;
      default:            state_d = pfrc_pkg::S_IDLE;
    endcase
  end

  // Rule memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (state_q == pfrc_pkg::S_WALK && cur_ok) rd_q <= mem[cur_ix];
    if (state_q == pfrc_pkg::S_APPLY && busy_q) begin
      if ((mode_q == pfrc_pkg::MODE_APPEND || mode_q == pfrc_pkg::MODE_INSERT))
        mem[free_ix] <= pkt_q;
      else if (mode_q == pfrc_pkg::MODE_REPLACE) mem[cur_ix] <= pkt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pfrc_pkg::S_IDLE && in_valid_i) begin
      mode_q  <= mode_i;
      chain_q <= chain_i;
      idx_q   <= index_i;
      pkt_q   <= '{smac: src_mac_i, dmac: dst_mac_i, sip: src_ip_i, dip: dst_ip_i,
                   proto: proto_i, sport: src_port_i, dport: dst_port_i,
                   flags: match_flags_i, target: target_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfrc_pkg::S_IDLE;
      for (int i = 0; i < RULES; i++) link_q[i] <= LW'(i + 1);
      for (int c = 0; c < 3; c++) begin
        head_q[c] <= None;
        dflt_q[c] <= pfrc_pkg::TgtAccept;
      end
      free_q    <= '0;
      cur_q     <= None;
      prev_q    <= None;
      pos_q     <= '0;
      busy_q    <= 1'b0;
      status_q  <= pfrc_pkg::ST_OK;
      verdict_q <= '0;
      differs_q <= 1'b0;
      hit_q     <= 1'b0;
      hpos_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && (cfg_data_i == pfrc_pkg::TgtDrop || cfg_data_i == pfrc_pkg::TgtAccept)) begin
        case (cfg_index_i)
          pfrc_pkg::CFG_INPUT:   dflt_q[0] <= cfg_data_i;
          pfrc_pkg::CFG_FORWARD: dflt_q[1] <= cfg_data_i;
          pfrc_pkg::CFG_OUTPUT:  dflt_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        pfrc_pkg::S_DEC: begin
          status_q  <= pfrc_pkg::ST_OK;
          verdict_q <= '0;
          differs_q <= 1'b0;
          hit_q     <= 1'b0;
          hpos_q    <= '0;
          pos_q     <= '0;
          prev_q    <= None;
          busy_q    <= 1'b0;
          cur_q     <= (chain_q == 2'd3) ? None : head_q[chain_q];
          case (mode_q)
            pfrc_pkg::MODE_APPEND, pfrc_pkg::MODE_INSERT, pfrc_pkg::MODE_CLEAR,
            pfrc_pkg::MODE_TEST: begin
              if (chain_q == 2'd3) status_q <= pfrc_pkg::ST_BAD_CHAIN;
              else if (mode_q == pfrc_pkg::MODE_APPEND || mode_q == pfrc_pkg::MODE_INSERT) begin
                if (free_q >= None) status_q <= pfrc_pkg::ST_FULL;
              end
            end
            pfrc_pkg::MODE_REPLACE, pfrc_pkg::MODE_DELETE: begin
              if (chain_q == 2'd3) status_q <= pfrc_pkg::ST_NO_ENTRY;
            end
            default: ;
          endcase
        end
        pfrc_pkg::S_WALK: begin
          if (!cur_ok || pos_q >= 9'(RULES)) begin
            if (mode_q == pfrc_pkg::MODE_TEST) begin
              verdict_q <= dflt_q[chain_q];
              differs_q <= pkt_q.target != dflt_q[chain_q];
            end else begin
              busy_q  <= (mode_q == pfrc_pkg::MODE_APPEND || mode_q == pfrc_pkg::MODE_INSERT);
              if (!(mode_q == pfrc_pkg::MODE_APPEND || mode_q == pfrc_pkg::MODE_INSERT))
                status_q <= pfrc_pkg::ST_NO_ENTRY;
              cur_q   <= None;
            end
          end else if (mode_q == pfrc_pkg::MODE_TEST) begin
            busy_q <= 1'b0;
          end else if (want_pos) begin
            busy_q  <= 1'b1;
          end else begin
            prev_q <= cur_q;
            cur_q  <= link_q[cur_ix];
            pos_q  <= pos_q + 9'd1;
          end
        end
        pfrc_pkg::S_CMP: begin
          if (match) begin
            hit_q     <= 1'b1;
            hpos_q    <= pos_q[7:0];
            verdict_q <= rd_q.target;
            differs_q <= pkt_q.target != rd_q.target;
          end else begin
            cur_q   <= link_q[cur_ix];
            pos_q   <= pos_q + 9'd1;
          end
        end
        pfrc_pkg::S_APPLY: begin
          if (busy_q) begin
            case (mode_q)
              pfrc_pkg::MODE_APPEND, pfrc_pkg::MODE_INSERT: begin
                free_q          <= link_q[free_ix];
                link_q[free_ix] <= cur_q;
                if (prev_q == None) head_q[chain_q] <= free_q;
                else link_q[prev_ix] <= free_q;
              end
              pfrc_pkg::MODE_DELETE: begin
                if (prev_q == None) head_q[chain_q] <= link_q[cur_ix];
                else link_q[prev_ix] <= link_q[cur_ix];
                link_q[cur_ix] <= free_q;
                free_q         <= cur_q;
              end
              default: ;
            endcase
          end
        end
        pfrc_pkg::S_CLEAR: begin
          if (!cur_ok || pos_q >= 9'(RULES)) begin
            head_q[chain_q] <= None;
          end else begin
            link_q[cur_ix] <= free_q;
            free_q         <= cur_q;
            cur_q          <= link_q[cur_ix];
            pos_q          <= pos_q + 9'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pfrc_checker.sv -----
// Port checker for the packet filter rule chain block, with its bind.
module pfrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [1:0] verdict_o,
  input logic       rule_hit_o
);

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while a result is pending");

  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after accept");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");

  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rule_hit_o |-> verdict_o == 2'd1 || verdict_o == 2'd2)
    else $error("hit without verdict");

endmodule

bind packet_filter_rule_chain pfrc_checker u_pfrc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .status_o(status_o),
  .verdict_o(verdict_o), .rule_hit_o(rule_hit_o)
);
